// ----- rtl/sacs_pkg.sv -----
// Shared types, codes and constants for the sorted adjacency compare scorer.
package sacs_pkg;

  localparam int MaxDegreeDef  = 256;
  localparam int NodeIdBitsDef = 16;

  localparam int CNT_W     = 33;
  localparam int Q_W       = 17;
  localparam int NC_W      = 17;
  localparam int NUM_W     = 50;
  localparam int DEN_W     = 34;
  localparam int DIV_STEPS = 17;
  localparam int DCNT_W    = 5;

  localparam logic [Q_W-1:0]   Q_ONE   = 17'h10000;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] FUNC_REF    = 2'd0;
  localparam logic [1:0] FUNC_CAND   = 2'd1;
  localparam logic [1:0] FUNC_NODE   = 2'd2;
  localparam logic [1:0] FUNC_REPORT = 2'd3;

  typedef enum logic [1:0] {
    DIV_PREC,
    DIV_REC,
    DIV_F1,
    DIV_ACC
  } div_sel_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] neighbor;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [CNT_W-1:0] matched;
    logic [CNT_W-1:0] added;
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] true_negative;
    logic [Q_W-1:0]   precision;
    logic [Q_W-1:0]   recall;
    logic [Q_W-1:0]   f1_score;
    logic [Q_W-1:0]   accuracy;
    logic             zero_denominator;
    logic             list_overflow;
  } res_t;

  typedef struct packed {
    logic     push_ref;
    logic     push_cand;
    logic     merge_init;
    logic     merge_step;
    logic     merge_done;
    logic     sq_load;
    logic     tn_load;
    logic     div_load;
    logic     div_step;
    logic     div_store;
    div_sel_e div_sel;
    logic     mul_load;
    logic     emit_report;
  } cmd_t;

  typedef struct packed {
    logic merge_more;
    logic div_busy;
  } status_t;

endpackage

// ----- rtl/sacs_dp.sv -----
// Datapath: neighbor list stores, merge counters, totals and the score divider.
module sacs_dp import sacs_pkg::*; #(
  parameter int MAX_DEGREE   = MaxDegreeDef,
  parameter int NODE_ID_BITS = NodeIdBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      neighbor_i,
  input  logic             cfg_we_i,
  input  logic [NC_W-1:0]  cfg_wdata_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  output res_t             res_o
);

  localparam int LEN_W = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_DEGREE);

  logic [NODE_ID_BITS-1:0] ref_mem  [MAX_DEGREE];
  logic [NODE_ID_BITS-1:0] cand_mem [MAX_DEGREE];
  logic [NODE_ID_BITS-1:0] id;
  logic [NODE_ID_BITS-1:0] ref_rd_q, cand_rd_q;

  logic [LEN_W-1:0] ref_len_q, cand_len_q;
  logic [LEN_W-1:0] ri_q, ri_d, cj_q, cj_d;
  logic [LEN_W-1:0] m_q, a_q, l_q, a_fin, l_fin;
  logic             ovf_q;
  logic [NC_W-1:0]  node_count_q;

  logic [CNT_W-1:0] tm_q, ta_q, tl_q;
  logic [CNT_W-1:0] sq_q, tn_q;
  logic [2*NC_W-1:0] sq_full;
  logic [CNT_W+1:0] used;
  logic [Q_W-1:0]   p_q, r_q, f1_q, acc_q;
  logic             zero_q;
  logic [2*Q_W-1:0] pr_q;

  logic [NUM_W-1:0] div_x;
  logic [DEN_W-1:0] div_d;
  logic [NUM_W-DIV_STEPS-1:0] div_hi;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_t;
  logic [DIV_STEPS-1:0] low_q;
  logic [Q_W-1:0]   q_q, q_res;
  logic [DCNT_W-1:0] cnt_q;
  logic             sat_q, dz_q;
  logic             take_ref, take_cand;
  res_t             res_q;
  res_t             res_node;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  assign id = NODE_ID_BITS'(neighbor_i);
  assign take_ref  = (ref_rd_q == cand_rd_q) || (ref_rd_q < cand_rd_q);
  assign take_cand = (ref_rd_q == cand_rd_q) || (ref_rd_q > cand_rd_q);

  always_comb begin
    ri_d = ri_q;
    cj_d = cj_q;
    if (cmd_i.merge_init) begin
      ri_d = '0;
      cj_d = '0;
    end else if (cmd_i.merge_step) begin
      if (take_ref) ri_d = ri_q + LEN_W'(1);
      if (take_cand) cj_d = cj_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_ref && ref_len_q < LenMax) begin
      ref_mem[ref_len_q[IDX_W-1:0]] <= id;
    end
    if (cmd_i.push_cand && cand_len_q < LenMax) begin
      cand_mem[cand_len_q[IDX_W-1:0]] <= id;
    end
    ref_rd_q  <= ref_mem[ri_d[IDX_W-1:0]];
    cand_rd_q <= cand_mem[cj_d[IDX_W-1:0]];
  end

  assign status_o.merge_more = (ri_q < ref_len_q) && (cj_q < cand_len_q);
  assign status_o.div_busy   = (cnt_q != '0);

  assign l_fin = l_q + (ref_len_q - ri_q);
  assign a_fin = a_q + (cand_len_q - cj_q);

  assign sq_full = node_count_q * node_count_q;
  assign used    = {2'b00, tm_q} + {2'b00, ta_q} + {2'b00, tl_q};

  always_comb begin
    res_node               = '0;
    res_node.matched       = CNT_W'(m_q);
    res_node.added         = CNT_W'(a_fin);
    res_node.lost          = CNT_W'(l_fin);
    res_node.list_overflow = ovf_q;
  end

  always_comb begin
    div_x = '0;
    div_d = '0;
    case (cmd_i.div_sel)
      DIV_PREC: begin
        div_x = NUM_W'({tm_q, 16'h0000});
        div_d = DEN_W'({1'b0, tm_q} + {1'b0, ta_q});
      end
      DIV_REC: begin
        div_x = NUM_W'({tm_q, 16'h0000});
        div_d = DEN_W'({1'b0, tm_q} + {1'b0, tl_q});
      end
      DIV_F1: begin
        div_x = NUM_W'({pr_q, 1'b0});
        div_d = DEN_W'({1'b0, p_q} + {1'b0, r_q});
      end
      DIV_ACC: begin
        div_x = NUM_W'({({1'b0, tm_q} + {1'b0, tn_q}), 16'h0000});
        div_d = DEN_W'(sq_q);
      end
      default: begin
        div_x = '0;
        div_d = '0;
      end
    endcase
  end

  assign div_hi = div_x[NUM_W-1:DIV_STEPS];
  assign rem_t  = {rem_q, low_q[DIV_STEPS-1]};
  assign q_res  = dz_q ? '0 : ((sat_q || q_q > Q_ONE) ? Q_ONE : q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_len_q    <= '0;
      cand_len_q   <= '0;
      ovf_q        <= 1'b0;
      tm_q         <= '0;
      ta_q         <= '0;
      tl_q         <= '0;
      node_count_q <= NC_W'(1);
      cnt_q        <= '0;
      ri_q         <= '0;
      cj_q         <= '0;
    end else begin
      ri_q <= ri_d;
      cj_q <= cj_d;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (cmd_i.push_ref) begin
        if (ref_len_q < LenMax) ref_len_q <= ref_len_q + LEN_W'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.push_cand) begin
        if (cand_len_q < LenMax) cand_len_q <= cand_len_q + LEN_W'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.merge_done) begin
        ref_len_q  <= '0;
        cand_len_q <= '0;
        tm_q <= sat_add(tm_q, CNT_W'(m_q));
        ta_q <= sat_add(ta_q, CNT_W'(a_fin));
        tl_q <= sat_add(tl_q, CNT_W'(l_fin));
      end
      if (cmd_i.div_load) begin
        cnt_q <= DCNT_W'(DIV_STEPS);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge_init) begin
      m_q <= '0;
      a_q <= '0;
      l_q <= '0;
    end else if (cmd_i.merge_step) begin
      if (take_ref && take_cand) m_q <= m_q + LEN_W'(1);
      else if (take_ref) l_q <= l_q + LEN_W'(1);
      else a_q <= a_q + LEN_W'(1);
    end
    if (cmd_i.sq_load) begin
      sq_q <= (sq_full > {1'b0, CNT_MAX}) ? CNT_MAX : sq_full[CNT_W-1:0];
    end
    if (cmd_i.tn_load) begin
      tn_q   <= (used >= {2'b00, sq_q}) ? '0 : CNT_W'({2'b00, sq_q} - used);
      zero_q <= 1'b0;
    end
    if (cmd_i.div_load) begin
      den_q <= div_d;
      dz_q  <= (div_d == '0);
      sat_q <= ({1'b0, div_hi} >= div_d);
      rem_q <= DEN_W'(div_hi);
      low_q <= div_x[DIV_STEPS-1:0];
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_t >= {1'b0, den_q}) begin
        rem_q <= DEN_W'(rem_t - {1'b0, den_q});
        q_q   <= {q_q[Q_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_t[DEN_W-1:0];
        q_q   <= {q_q[Q_W-2:0], 1'b0};
      end
      low_q <= {low_q[DIV_STEPS-2:0], 1'b0};
    end
    if (cmd_i.div_store) begin
      if (dz_q) zero_q <= 1'b1;
      case (cmd_i.div_sel)
        DIV_PREC: p_q   <= q_res;
        DIV_REC:  r_q   <= q_res;
        DIV_F1:   f1_q  <= q_res;
        DIV_ACC:  acc_q <= q_res;
        default:  p_q   <= p_q;
      endcase
    end
    if (cmd_i.mul_load) pr_q <= p_q * r_q;
    if (cmd_i.merge_done) begin
      res_q                  <= res_node;
    end else if (cmd_i.emit_report) begin
      res_q.kind             <= 1'b1;
      res_q.matched          <= tm_q;
      res_q.added            <= ta_q;
      res_q.lost             <= tl_q;
      res_q.true_negative    <= tn_q;
      res_q.precision        <= p_q;
      res_q.recall           <= r_q;
      res_q.f1_score         <= f1_q;
      res_q.accuracy         <= acc_q;
      res_q.zero_denominator <= zero_q;
      res_q.list_overflow    <= ovf_q;
    end
  end

  assign res_o = res_q;

  a_ref_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ref_len_q <= LenMax) && (cand_len_q <= LenMax))
    else $error("list length beyond store depth");

  a_div_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DCNT_W'(DIV_STEPS))
    else $error("divider step count out of range");

  a_merge_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.merge_step |-> (ri_q < ref_len_q) && (cj_q < cand_len_q))
    else $error("merge step past end of a list");

endmodule

// ----- rtl/sacs_ctrl.sv -----
// Controller state machine that sequences loads, merges and score reports.
module sacs_ctrl import sacs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output logic       busy_o,
  output logic       res_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_TN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_MUL,
    ST_EMIT
  } state_e;

  state_e   state_q;
  div_sel_e sel_q;
  logic     res_valid_q;
  logic     accept;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign res_valid_o = res_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_REF:  cmd_o.push_ref   = 1'b1;
            FUNC_CAND: cmd_o.push_cand  = 1'b1;
            FUNC_NODE: cmd_o.merge_init = 1'b1;
            default:   cmd_o.sq_load    = 1'b1;
          endcase
        end
      end
      ST_MERGE: begin
        if (status_i.merge_more) cmd_o.merge_step = 1'b1;
        else cmd_o.merge_done = 1'b1;
      end
      ST_TN:       cmd_o.tn_load = 1'b1;
      ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV_RUN: begin
        if (status_i.div_busy) cmd_o.div_step = 1'b1;
        else cmd_o.div_store = 1'b1;
      end
      ST_MUL:  cmd_o.mul_load = 1'b1;
      ST_EMIT: cmd_o.emit_report = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= DIV_PREC;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && func_i == FUNC_NODE) begin
            state_q <= ST_MERGE;
          end else if (accept && func_i == FUNC_REPORT) begin
            state_q <= ST_TN;
            sel_q   <= DIV_PREC;
          end
        end
        ST_MERGE: begin
          if (!status_i.merge_more) begin
            state_q     <= ST_IDLE;
            res_valid_q <= 1'b1;
          end
        end
        ST_TN:       state_q <= ST_DIV_LOAD;
        ST_DIV_LOAD: state_q <= ST_DIV_RUN;
        ST_DIV_RUN: begin
          if (!status_i.div_busy) begin
            case (sel_q)
              DIV_PREC: begin
                sel_q   <= DIV_REC;
                state_q <= ST_DIV_LOAD;
              end
              DIV_REC: state_q <= ST_MUL;
              DIV_F1: begin
                sel_q   <= DIV_ACC;
                state_q <= ST_DIV_LOAD;
              end
              default: state_q <= ST_EMIT;
            endcase
          end
        end
        ST_MUL: begin
          sel_q   <= DIV_F1;
          state_q <= ST_DIV_LOAD;
        end
        ST_EMIT: begin
          state_q     <= ST_IDLE;
          res_valid_q <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held for two cycles");

  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !(cmd_o.push_ref || cmd_o.push_cand))
    else $error("list write while busy");

  a_step_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> status_i.div_busy)
    else $error("divider stepped while idle");

endmodule

// ----- rtl/sorted_adjacency_compare_scorer_top.sv -----
// Top level of the sorted adjacency compare scorer.
// A neighbor load request is taken in idle and busy stays low, so loads run back to back.
// An end-of-node request runs merge steps until one list is exhausted (at most the sum of
// both list lengths); the merge walks both list memories one element per cycle.
// A report request runs four 17-step serial divisions; results cannot be stalled. Reset
// clears lengths, totals and the overflow flag and sets node_count to 1; list memories
// are not cleared.
module sorted_adjacency_compare_scorer_top import sacs_pkg::*; #(
  parameter int MAX_DEGREE   = MaxDegreeDef,
  parameter int NODE_ID_BITS = NodeIdBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  req_t            req_i,
  input  logic            cfg_we_i,
  input  logic [NC_W-1:0] cfg_wdata_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  cmd_t    cmd;
  status_t status;

  sacs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .func_i      (req_i.func),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .res_valid_o (res_valid_o)
  );

  sacs_dp #(
    .MAX_DEGREE   (MAX_DEGREE),
    .NODE_ID_BITS (NODE_ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .neighbor_i  (req_i.neighbor),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res_o)
  );

endmodule

// ----- bench/sorted_adjacency_compare_scorer_top_tb.sv -----
// Self-checking testbench for the sorted adjacency compare scorer.
module sorted_adjacency_compare_scorer_top_tb import sacs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {ENT_REQ, ENT_CFG, ENT_HOLD} ent_kind_e;
  typedef struct {
    ent_kind_e       kind;
    req_t            req;
    logic [NC_W-1:0] val;
  } pend_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  req_t            req_i = '0;
  logic            cfg_we_i = 1'b0;
  logic [NC_W-1:0] cfg_wdata_i = '0;
  logic            res_valid_o;
  res_t            res_o;

  pend_t pend_q[$];
  res_t  score_q[$];

  logic [15:0] ref_nb[$];
  logic [15:0] cand_nb[$];
  logic        ovf_seen = 1'b0;
  logic [63:0] tot_m = 0, tot_a = 0, tot_l = 0;
  logic [63:0] nodes = 1;

  int errors = 0;
  int settle = 0;
  int accepted = 0;
  int quiet = 0;

  sorted_adjacency_compare_scorer_top dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .cfg_we_i, .cfg_wdata_i, .res_valid_o, .res_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'(CNT_MAX)) ? 64'(CNT_MAX) : s;
  endfunction

  function automatic logic [63:0] q_frac(logic [63:0] num, logic [63:0] den, inout logic zd);
    logic [63:0] q;
    if (den == 0) begin
      zd = 1'b1;
      return 0;
    end
    q = (num << 16) / den;
    return (q > 64'(Q_ONE)) ? 64'(Q_ONE) : q;
  endfunction

  task automatic score_request(req_t r);
    res_t        o;
    int          i, j;
    logic [63:0] m, a, l, sq, used, tn, p, rc, f;
    logic        zd;
    o = '0;
    if (r.func == FUNC_REF || r.func == FUNC_CAND) begin
      if (r.func == FUNC_REF && ref_nb.size() < 256) ref_nb = {ref_nb, r.neighbor};
      else if (r.func == FUNC_CAND && cand_nb.size() < 256) cand_nb = {cand_nb, r.neighbor};
      else ovf_seen = 1'b1;
      return;
    end
    o.list_overflow = ovf_seen;
    if (r.func == FUNC_NODE) begin
      i = 0; j = 0; m = 0; a = 0; l = 0;
      while (i < ref_nb.size() && j < cand_nb.size()) begin
        if (ref_nb[i] == cand_nb[j]) begin
          m++; i++; j++;
        end else if (ref_nb[i] < cand_nb[j]) begin
          l++; i++;
        end else begin
          a++; j++;
        end
      end
      l += ref_nb.size() - i;
      a += cand_nb.size() - j;
      ref_nb.delete();
      cand_nb.delete();
      tot_m = sat_sum(tot_m, m);
      tot_a = sat_sum(tot_a, a);
      tot_l = sat_sum(tot_l, l);
      o.matched = m; o.added = a; o.lost = l;
    end else begin
      zd = 1'b0;
      sq = nodes * nodes;
      if (sq > 64'(CNT_MAX)) sq = 64'(CNT_MAX);
      used = tot_m + tot_a + tot_l;
      tn = (used >= sq) ? 0 : sq - used;
      p = q_frac(tot_m, tot_m + tot_a, zd);
      rc = q_frac(tot_m, tot_m + tot_l, zd);
      if (p + rc == 0) begin
        zd = 1'b1;
        f = 0;
      end else begin
        f = (2 * p * rc) / (p + rc);
        if (f > 64'(Q_ONE)) f = 64'(Q_ONE);
      end
      o.kind = 1'b1;
      o.matched = tot_m; o.added = tot_a; o.lost = tot_l;
      o.true_negative = tn;
      o.precision = p; o.recall = rc; o.f1_score = f;
      o.accuracy = q_frac(tot_m + tn, sq, zd);
      o.zero_denominator = zd;
    end
    score_q = {score_q, o};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      if (cfg_we_i) nodes = cfg_wdata_i;
      cfg_we_i <= 1'b0;
      if (start && !busy) begin
        score_request(req_i);
        accepted++;
      end
      if (start && busy) begin
      end else if (pend_q.size() == 0) begin
        start <= 1'b0;
      end else if (pend_q[0].kind == ENT_REQ) begin
        if (!(accepted > 700 && accepted < 1000) && $urandom_range(99) < 17) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          req_i <= pend_q[0].req;
          void'(pend_q.pop_front());
        end
      end else begin
        start <= 1'b0;
        if (score_q.size() != 0 || busy || start) settle = 0;
        else settle++;
        if (settle >= 8) begin
          if (pend_q[0].kind == ENT_CFG) begin
            cfg_we_i <= 1'b1;
            cfg_wdata_i <= pend_q[0].val;
          end
          void'(pend_q.pop_front());
          settle = 0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (score_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: %p", res_o);
      end else begin
        if (res_o !== score_q[0]) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", score_q[0], res_o);
        end
        void'(score_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || cfg_we_i || settle > 0) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] f, logic [15:0] nb);
    pend_t e;
    e.kind = ENT_REQ;
    e.req.func = f;
    e.req.neighbor = nb;
    e.val = '0;
    pend_q = {pend_q, e};
  endtask

  task automatic push_ctl(ent_kind_e k, logic [NC_W-1:0] v);
    pend_t e;
    e.kind = k;
    e.req = '0;
    e.val = v;
    pend_q = {pend_q, e};
  endtask

  task automatic push_node(int maxlen, bit sorted);
    logic [15:0] rl[$];
    logic [15:0] cl[$];
    int          n;
    n = $urandom_range(maxlen);
    repeat (n) rl = {rl, ($urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(63)))};
    foreach (rl[k]) if ($urandom_range(2) != 0) cl = {cl, rl[k]};
    repeat ($urandom_range(maxlen / 2)) cl = {cl, 16'($urandom_range(63))};
    if (sorted) begin
      rl.sort();
      cl.sort();
    end
    foreach (rl[k]) push_req(FUNC_REF, rl[k]);
    foreach (cl[k]) push_req(FUNC_CAND, cl[k]);
    push_req(FUNC_NODE, 16'($urandom));
  endtask

  initial begin
    logic [NC_W-1:0] cfgs[5];
    cfgs = '{17'd1, 17'd65536, 17'd0, 17'd131071, 17'd0};
    cfgs[4] = 17'($urandom_range(2, 4000));

    push_req(FUNC_REPORT, 16'hFFFF);
    push_req(FUNC_NODE, 16'h0000);
    push_req(FUNC_REF, 16'h0000);
    push_req(FUNC_REF, 16'h0005);
    push_req(FUNC_REF, 16'hFFFF);
    push_req(FUNC_CAND, 16'h0000);
    push_req(FUNC_CAND, 16'h0007);
    push_req(FUNC_CAND, 16'hFFFF);
    push_req(FUNC_NODE, 16'hAAAA);
    push_req(FUNC_REF, 16'h0009);
    push_req(FUNC_REF, 16'h0003);
    push_req(FUNC_CAND, 16'h0003);
    push_req(FUNC_NODE, 16'h5555);
    push_req(FUNC_CAND, 16'h1234);
    push_req(FUNC_NODE, 16'h0000);
    push_req(FUNC_REPORT, 16'h0000);

    foreach (cfgs[c]) begin
      push_ctl(ENT_CFG, cfgs[c]);
      if (c == 1) begin
        repeat (260) push_req(FUNC_REF, 16'($urandom));
        repeat (258) push_req(FUNC_CAND, 16'($urandom));
        push_req(FUNC_NODE, 16'h0000);
      end
      repeat (36) begin
        case ($urandom_range(9))
          0: push_req(2'($urandom_range(1)), 16'($urandom));
          1: push_node(6, 1'b0);
          2: push_req(FUNC_REPORT, 16'($urandom));
          default: push_node(8, 1'b1);
        endcase
      end
      if (c == 2) push_ctl(ENT_HOLD, '0);
      push_req(FUNC_REPORT, 16'($urandom));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pend_q.size() != 0 || start || score_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && score_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
